@@ rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and sizes for the frame receive and unmask datapath.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LEN_BITS     = 64;   // width kept of the decoded length
  localparam int OUT_LEN_BITS = 64;   // width of the length on the result port
  localparam int KEY_BYTES    = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] OPC_CLOSE   = 4'd8;
  localparam logic [6:0] LEN16_CODE  = 7'd126;
  localparam logic [6:0] LEN64_CODE  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAYLOAD,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_CLOSE   = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       segment_start;
  } in_item_t;

  typedef struct packed {
    event_kind_t             event_kind;
    logic [7:0]              payload_byte;
    logic [3:0]              frame_opcode;
    logic [OUT_LEN_BITS-1:0] frame_length;
    logic                    last_of_payload;
  } out_item_t;

  // Classified request passed from the parser to the result stage.
  typedef struct packed {
    event_kind_t         kind;
    logic [7:0]          data;
    logic [7:0]          key_byte;
    logic [3:0]          opcode;
    logic [LEN_BITS-1:0] length;
    logic                last;
  } cmd_t;

endpackage

@@ rtl/websocket_frame_deframer_unit.sv @@
// A result passes through the request queue and then the output register.
// Throughput: one received byte per cycle while full is low; each byte is parsed combinationally.
// A four-entry queue and the output register absorb a stalled result side.
// Reset (synchronous, active high) empties both and restarts header parsing.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers from a byte stream and emits header and close events and unmasked payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wsd_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output wsd_pkg::out_item_t out_item
);
  import wsd_pkg::*;

  logic cmd_push;
  logic cmd_full;
  cmd_t cmd_in;
  logic q_pop;
  logic q_empty;
  cmd_t cmd_out;

  wsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd      (cmd_in)
  );

  wsd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .full   (cmd_full),
    .wr_cmd (cmd_in),
    .rd     (q_pop),
    .empty  (q_empty),
    .rd_cmd (cmd_out)
  );

  wsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .cmd      (cmd_out),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

@@ rtl/wsd_front.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the header of each segment and classifies every received byte.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  wsd_pkg::in_item_t in_item,
  output logic             cmd_push,
  input  logic             cmd_full,
  output wsd_pkg::cmd_t    cmd
);
  import wsd_pkg::*;

  phase_t                        phase;
  phase_t                        phase_next;
  phase_t                        cur;
  logic [3:0]                    opcode;
  logic                          mask_on;
  logic [LEN_BITS-1:0]           len_acc;
  logic [3:0]                    ext_left;
  logic [KEY_BYTES-1:0][7:0]     key;
  logic [LEN_BITS-1:0]           remaining;
  logic [1:0]                    key_pos;

  logic                accept;
  logic [7:0]          b;
  logic [6:0]          lcode;
  logic                ext_code;
  logic                is_close;
  logic [LEN_BITS-1:0] len_shift;
  logic [3:0]          ext_left_dec;
  logic                hdr_done;
  logic [LEN_BITS-1:0] hdr_len;
  logic [7:0]          key_byte;
  logic [LEN_BITS-1:0] rem_dec;
  logic                rem_last;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // A segment start forces the byte to be taken as the first header byte.
  always_comb begin
    cur          = in_item.segment_start ? PH_HDR0 : phase;
    b            = in_item.rx_byte;
    lcode        = b[6:0];
    ext_code     = (lcode == LEN16_CODE) || (lcode == LEN64_CODE);
    is_close     = (b[3:0] == OPC_CLOSE);
    len_shift    = {len_acc[LEN_BITS-9:0], b};
    ext_left_dec = ext_left - 4'd1;
    hdr_done     = ((cur == PH_HDR1) && !ext_code && !b[7])
                || ((cur == PH_EXT) && (ext_left_dec == 4'd0) && !mask_on)
                || ((cur == PH_KEY) && (key_pos == 2'(KEY_BYTES - 1)));
    if (cur == PH_HDR1) begin
      hdr_len = LEN_BITS'(lcode);
    end else if (cur == PH_EXT) begin
      hdr_len = len_shift;
    end else begin
      hdr_len = len_acc;
    end
    key_byte = mask_on ? key[2'(KEY_BYTES - 1) - key_pos] : 8'h00;
    rem_dec  = remaining - LEN_BITS'(1);
    rem_last = (remaining == LEN_BITS'(1));
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (cur)
        PH_HDR0:    phase_next = is_close ? PH_IDLE : PH_HDR1;
        PH_HDR1:    phase_next = ext_code ? PH_EXT : (b[7] ? PH_KEY : PH_PAYLOAD);
        PH_EXT:     phase_next = (ext_left_dec != 4'd0) ? PH_EXT
                               : (mask_on ? PH_KEY : PH_PAYLOAD);
        PH_KEY:     phase_next = PH_KEY;
        PH_PAYLOAD: phase_next = rem_last ? PH_IDLE : PH_PAYLOAD;
        PH_IDLE:    phase_next = PH_IDLE;
        default:    phase_next = PH_HDR0;
      endcase
      if (hdr_done) begin
        phase_next = (hdr_len == '0) ? PH_IDLE : PH_PAYLOAD;
      end
    end
  end

  always_comb begin
    cmd_push     = accept && (hdr_done || (cur == PH_PAYLOAD)
                              || ((cur == PH_HDR0) && is_close));
    cmd.kind     = EV_HEADER;
    cmd.data     = 8'h00;
    cmd.key_byte = 8'h00;
    cmd.opcode   = (cur == PH_HDR0) ? b[3:0] : opcode;
    cmd.length   = hdr_len;
    cmd.last     = hdr_done && (hdr_len == '0);
    if (cur == PH_HDR0) begin
      cmd.kind   = EV_CLOSE;
      cmd.length = '0;
      cmd.last   = 1'b0;
    end else if (cur == PH_PAYLOAD) begin
      cmd.kind     = EV_PAYLOAD;
      cmd.data     = b;
      cmd.key_byte = key_byte;
      cmd.length   = len_acc;
      cmd.last     = rem_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      opcode    <= '0;
      mask_on   <= 1'b0;
      len_acc   <= '0;
      ext_left  <= '0;
      key       <= '0;
      remaining <= '0;
      key_pos   <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        unique case (cur)
          PH_HDR0: begin
            opcode    <= b[3:0];
            mask_on   <= 1'b0;
            len_acc   <= '0;
            ext_left  <= '0;
            key       <= '0;
            remaining <= '0;
            key_pos   <= '0;
          end
          PH_HDR1: begin
            mask_on <= b[7];
            if (ext_code) begin
              ext_left <= (lcode == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
            end else begin
              len_acc <= hdr_len;
            end
          end
          PH_EXT: begin
            len_acc  <= len_shift;
            ext_left <= ext_left_dec;
          end
          PH_KEY: begin
            key     <= {key[KEY_BYTES-2:0], b};
            key_pos <= key_pos + 2'd1;
          end
          PH_PAYLOAD: begin
            key_pos   <= key_pos + 2'd1;
            remaining <= rem_dec;
          end
          PH_IDLE: begin
          end
          default: begin
          end
        endcase
        if (hdr_done) begin
          remaining <= hdr_len;
          key_pos   <= '0;
        end
      end
    end
  end

endmodule

@@ rtl/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer request queue
// Short first-in first-out buffer between the parser and the result stage.
// ----------------------------------------------------------------------------
module wsd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  output logic          full,
  input  wsd_pkg::cmd_t wr_cmd,
  input  logic          rd,
  output logic          empty,
  output wsd_pkg::cmd_t rd_cmd
);
  import wsd_pkg::*;

  cmd_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full   = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/wsd_back.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer result stage
// Unmasks payload bytes and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  wsd_pkg::cmd_t      cmd,
  output logic               empty,
  input  logic               pop,
  output wsd_pkg::out_item_t out_item
);
  import wsd_pkg::*;

  logic      valid;
  out_item_t result;

  // A new request is taken when the register is free or is being drained.
  assign q_pop    = !q_empty && (!valid || pop);
  assign empty    = !valid;
  assign out_item = result;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.event_kind      <= cmd.kind;
      result.payload_byte    <= cmd.data ^ cmd.key_byte;
      result.frame_opcode    <= cmd.opcode;
      result.frame_length    <= OUT_LEN_BITS'(cmd.length);
      result.last_of_payload <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_pop) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

endmodule

@@ rtl/wsd_checker.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the top-level ports for inconsistent results over time.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input wsd_pkg::out_item_t out_item
);
  import wsd_pkg::*;

  // Nothing can be waiting straight after a reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown straight after reset");

  // A waiting request that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before it was taken");

  // A close event carries the close opcode, no length and no last flag.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.event_kind == EV_CLOSE) |->
      (out_item.frame_opcode == OPC_CLOSE && out_item.frame_length == '0
       && !out_item.last_of_payload))
    else $error("malformed close event");

  // A header event is flagged last exactly when its length is zero.
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.event_kind == EV_HEADER) |->
      (out_item.last_of_payload == (out_item.frame_length == '0)))
    else $error("header last flag does not match its length");

  // A payload byte always belongs to a frame of non-zero length.
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.event_kind == EV_PAYLOAD) |->
      (out_item.frame_length != '0))
    else $error("payload byte from a frame of zero length");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (.*);
